@@ rtl/gqv_pkg.sv @@
// shared types, constants and arithmetic helpers for the glyph quad vertex generator
`default_nettype none
package gqv_pkg;

  localparam int ATLAS_CELLS = 16;
  localparam int CELL_BITS   = $clog2(ATLAS_CELLS);

  localparam int POS_W  = 24;
  localparam int ACC_W  = 28;
  localparam int TEX_W  = 17;
  localparam int MUL_AW = 25;
  localparam int MUL_BW = 15;
  localparam int PROD_W = MUL_AW + 1 + MUL_BW;
  localparam int CFG_W  = 25;
  localparam int IDX_W  = 3;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic       KIND_START   = 1'b0;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CELL_W   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELL_H   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV_W    = 3'd3;
  localparam logic [IDX_W-1:0] REG_INV_H    = 3'd4;
  localparam logic [IDX_W-1:0] REG_MARGIN_L = 3'd5;
  localparam logic [IDX_W-1:0] REG_MARGIN_R = 3'd6;

  localparam logic [8:0]  RST_CELL_W   = 9'd16;
  localparam logic [8:0]  RST_CELL_H   = 9'd16;
  localparam logic [15:0] RST_SCALE    = 16'd256;
  localparam logic [24:0] RST_INV_W    = 25'd65536;
  localparam logic [24:0] RST_INV_H    = 25'd65536;
  localparam logic [7:0]  RST_MARGIN_L = 8'd8;
  localparam logic [7:0]  RST_MARGIN_R = 8'd8;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_CW,
    ST_MUL_MG,
    ST_MUL_CH,
    ST_MUL_U0,
    ST_MUL_U1,
    ST_MUL_V0,
    ST_MUL_V1,
    ST_FIN,
    ST_EMIT,
    ST_NL_MUL,
    ST_NL_ADD
  } state_t;

  typedef enum logic [2:0] {
    MS_CW,
    MS_MG,
    MS_CH,
    MS_U0,
    MS_U1,
    MS_V0,
    MS_V1
  } mul_sel_t;

  typedef enum logic [3:0] {
    USE_NONE,
    USE_XADD,
    USE_XSUB,
    USE_YADD,
    USE_U0,
    USE_U1,
    USE_V0,
    USE_V1,
    USE_NL
  } use_sel_t;

  typedef struct packed {
    logic      load;
    mul_sel_t  mul_sel;
    use_sel_t  use_sel;
    logic [1:0] corner;
    logic      quad_done;
  } gqv_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_newline;
  } gqv_sts_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(24'sh7FFFFF));
    lo = ACC_W'(signed'(24'sh800000));
    if (v > hi) begin
      sat_pos = 24'sh7FFFFF;
    end else if (v < lo) begin
      sat_pos = 24'sh800000;
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

  // floor to q1.16 and clamp into 0..1.0
  function automatic logic [TEX_W-1:0] tex_clamp(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-9:0] q;
    q = p[PROD_W-1:8];
    if (p <= 0) begin
      tex_clamp = '0;
    end else if (q > (PROD_W-8)'(65536)) begin
      tex_clamp = 17'd65536;
    end else begin
      tex_clamp = q[TEX_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/gqv_channels.sv @@
// request channel interfaces for input items and vertex results
`default_nettype none
interface gqv_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (output valid, kind, char_code, start_x, start_y, input ready);
  modport sink   (input valid, kind, char_code, start_x, start_y, output ready);
endinterface

interface gqv_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [16:0] tex_u;
  logic [16:0] tex_v;
  logic        last_vertex;

  modport source (output valid, pos_x, pos_y, tex_u, tex_v, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, tex_u, tex_v, last_vertex, output ready);
endinterface
`default_nettype wire

@@ rtl/gqv_ctrl.sv @@
// sequencing state machine for the glyph quad vertex generator
`default_nettype none
module gqv_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire gqv_pkg::gqv_sts_t sts_i,
  output gqv_pkg::gqv_cmd_t    cmd_o
);
  import gqv_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    corner_nxt      = corner_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.mul_sel   = MS_CW;
    cmd_o.use_sel   = USE_NONE;
    cmd_o.corner    = corner_r;
    cmd_o.quad_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
        if (in_valid) begin
          if (sts_i.is_start) begin
            state_nxt = ST_IDLE;
          end else if (sts_i.is_newline) begin
            state_nxt = ST_NL_MUL;
          end else begin
            state_nxt = ST_MUL_CW;
          end
        end
      end
      ST_MUL_CW: begin
        cmd_o.mul_sel = MS_CW;
        state_nxt     = ST_MUL_MG;
      end
      ST_MUL_MG: begin
        cmd_o.mul_sel = MS_MG;
        cmd_o.use_sel = USE_XADD;
        state_nxt     = ST_MUL_CH;
      end
      ST_MUL_CH: begin
        cmd_o.mul_sel = MS_CH;
        cmd_o.use_sel = USE_XSUB;
        state_nxt     = ST_MUL_U0;
      end
      ST_MUL_U0: begin
        cmd_o.mul_sel = MS_U0;
        cmd_o.use_sel = USE_YADD;
        state_nxt     = ST_MUL_U1;
      end
      ST_MUL_U1: begin
        cmd_o.mul_sel = MS_U1;
        cmd_o.use_sel = USE_U0;
        state_nxt     = ST_MUL_V0;
      end
      ST_MUL_V0: begin
        cmd_o.mul_sel = MS_V0;
        cmd_o.use_sel = USE_U1;
        state_nxt     = ST_MUL_V1;
      end
      ST_MUL_V1: begin
        cmd_o.mul_sel = MS_V1;
        cmd_o.use_sel = USE_V0;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.use_sel = USE_V1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (corner_r == CORNER_LAST) begin
            cmd_o.quad_done = 1'b1;
            corner_nxt      = '0;
            state_nxt       = ST_IDLE;
          end else begin
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      ST_NL_MUL: begin
        cmd_o.mul_sel = MS_CH;
        state_nxt     = ST_NL_ADD;
      end
      ST_NL_ADD: begin
        cmd_o.use_sel = USE_NL;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt  = ST_IDLE;
        corner_nxt = '0;
      end
    endcase
  end

  // no new request may start while a quad is still being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid))
    else $error("input accepted while a vertex is pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && corner_r == CORNER_LAST |=> in_ready && !out_valid)
    else $error("controller did not return to idle after the fourth vertex");

  a_corner_rest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_EMIT |-> corner_r == 2'd0)
    else $error("corner counter not cleared outside vertex delivery");

  a_newline_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && sts_i.is_newline && !sts_i.is_start |=> ##1 !out_valid)
    else $error("newline produced a vertex");

endmodule
`default_nettype wire

@@ rtl/gqv_dp.sv @@
// config registers, pen state, shared multiplier and vertex output mux
`default_nettype none
module gqv_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [gqv_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [gqv_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                 in_kind,
  input  wire logic [7:0]           in_char_code,
  input  wire logic signed [15:0]   in_start_x,
  input  wire logic signed [15:0]   in_start_y,
  input  wire gqv_pkg::gqv_cmd_t    cmd_i,
  output gqv_pkg::gqv_sts_t         sts_o,
  output logic signed [23:0]        out_pos_x,
  output logic signed [23:0]        out_pos_y,
  output logic [16:0]               out_tex_u,
  output logic [16:0]               out_tex_v,
  output logic                      out_last_vertex
);
  import gqv_pkg::*;

  logic [8:0]  cell_w_r, cell_h_r;
  logic [15:0] scale_r;
  logic [24:0] inv_w_r, inv_h_r;
  logic [7:0]  margin_l_r, margin_r_r;

  logic signed [POS_W-1:0] pen_x_r, pen_y_r, origin_x_r;
  logic signed [ACC_W-1:0] xacc_r, xacc_nxt, yacc_r, yacc_nxt;
  logic signed [MUL_BW-1:0] u0_r, u1_r, v0_r, v1_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [TEX_W-1:0] tu0_r, tu1_r, tv0_r, tv1_r;

  logic [MUL_AW-1:0]        mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic [CELL_BITS-1:0]     mx, my;
  logic [CELL_BITS:0]       mx1, my1;
  logic [8:0]               margin_sum;
  logic signed [ACC_W-1:0]  prod_acc;
  logic signed [POS_W-1:0]  x1_sat, y1_sat;
  logic                     right_side, bottom_side;

  assign sts_o.is_start   = (in_kind == KIND_START);
  assign sts_o.is_newline = (in_char_code == CHAR_NEWLINE);

  assign mx  = in_char_code[CELL_BITS-1:0];
  assign my  = in_char_code[2*CELL_BITS-1:CELL_BITS];
  assign mx1 = {1'b0, mx} + (CELL_BITS+1)'(1);
  assign my1 = {1'b0, my} + (CELL_BITS+1)'(1);
  assign margin_sum = {1'b0, margin_l_r} + {1'b0, margin_r_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_w_r   <= RST_CELL_W;
      cell_h_r   <= RST_CELL_H;
      scale_r    <= RST_SCALE;
      inv_w_r    <= RST_INV_W;
      inv_h_r    <= RST_INV_H;
      margin_l_r <= RST_MARGIN_L;
      margin_r_r <= RST_MARGIN_R;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_W:   cell_w_r   <= cfg_data[8:0];
        REG_CELL_H:   cell_h_r   <= cfg_data[8:0];
        REG_SCALE:    scale_r    <= cfg_data[15:0];
        REG_INV_W:    inv_w_r    <= cfg_data[24:0];
        REG_INV_H:    inv_h_r    <= cfg_data[24:0];
        REG_MARGIN_L: margin_l_r <= cfg_data[7:0];
        REG_MARGIN_R: margin_r_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MS_CW: begin
        mul_a = MUL_AW'(scale_r);
        mul_b = MUL_BW'({1'b0, cell_w_r});
      end
      MS_MG: begin
        mul_a = MUL_AW'(scale_r);
        mul_b = MUL_BW'({1'b0, margin_sum});
      end
      MS_CH: begin
        mul_a = MUL_AW'(scale_r);
        mul_b = MUL_BW'({1'b0, cell_h_r});
      end
      MS_U0: begin
        mul_a = inv_w_r;
        mul_b = u0_r;
      end
      MS_U1: begin
        mul_a = inv_w_r;
        mul_b = u1_r;
      end
      MS_V0: begin
        mul_a = inv_h_r;
        mul_b = v0_r;
      end
      MS_V1: begin
        mul_a = inv_h_r;
        mul_b = v1_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = $signed({1'b0, mul_a}) * mul_b;
  assign prod_acc = prod_r[ACC_W-1:0];

  always_comb begin
    xacc_nxt = xacc_r;
    yacc_nxt = yacc_r;
    case (cmd_i.use_sel)
      USE_XADD: xacc_nxt = ACC_W'(pen_x_r) + prod_acc;
      USE_XSUB: xacc_nxt = xacc_r - prod_acc;
      USE_YADD: yacc_nxt = ACC_W'(pen_y_r) + prod_acc;
      USE_NL:   yacc_nxt = ACC_W'(pen_y_r) + prod_acc;
      default: ;
    endcase
  end

  assign x1_sat = sat_pos(xacc_r);
  assign y1_sat = sat_pos(yacc_r);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    xacc_r <= xacc_nxt;
    yacc_r <= yacc_nxt;
    if (cmd_i.load) begin
      // texel spans of the glyph cell, left and right margins trimmed
      u0_r <= MUL_BW'(mx) * MUL_BW'(cell_w_r) + MUL_BW'(margin_l_r);
      u1_r <= MUL_BW'(mx1) * MUL_BW'(cell_w_r) - MUL_BW'(margin_r_r);
      v0_r <= MUL_BW'(my) * MUL_BW'(cell_h_r);
      v1_r <= MUL_BW'(my1) * MUL_BW'(cell_h_r);
    end
    case (cmd_i.use_sel)
      USE_U0: tu0_r <= tex_clamp(prod_r);
      USE_U1: tu1_r <= tex_clamp(prod_r);
      USE_V0: tv0_r <= tex_clamp(prod_r);
      USE_V1: tv1_r <= tex_clamp(prod_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      origin_x_r <= '0;
    end else begin
      if (cmd_i.load && sts_o.is_start) begin
        origin_x_r <= {in_start_x, 8'd0};
        pen_x_r    <= {in_start_x, 8'd0};
        pen_y_r    <= {in_start_y, 8'd0};
      end else if (cmd_i.use_sel == USE_NL) begin
        pen_x_r <= origin_x_r;
        pen_y_r <= sat_pos(yacc_nxt);
      end else if (cmd_i.quad_done) begin
        pen_x_r <= x1_sat;
      end
    end
  end

  // corners go (0,0),(1,0),(1,1),(0,1)
  assign right_side  = (cmd_i.corner == 2'd1) || (cmd_i.corner == 2'd2);
  assign bottom_side = cmd_i.corner[1];

  assign out_pos_x       = right_side  ? x1_sat : pen_x_r;
  assign out_pos_y       = bottom_side ? y1_sat : pen_y_r;
  assign out_tex_u       = right_side  ? tu1_r  : tu0_r;
  assign out_tex_v       = bottom_side ? tv1_r  : tv0_r;
  assign out_last_vertex = (cmd_i.corner == CORNER_LAST);

endmodule
`default_nettype wire

@@ rtl/glyph_quad_vertex_generator.sv @@
// Glyph quad vertex generator: one item at a time through a shared multiplier.
// A character is accepted, then runs seven products on the shared 26x15 multiplier, one
// finishing step and four vertex steps, each vertex waiting on the sink; no new item is
// accepted until the last vertex has gone out. A newline adds a multiply and an add step
// to its accept, a start item is only accepted; neither emits a vertex.
// Synchronous active-low reset restores the register defaults and clears pen and origin.
`default_nettype none
module glyph_quad_vertex_generator (
  input  wire logic clk,
  input  wire logic rst_n,
  gqv_in_if.sink    in_ch,
  gqv_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [gqv_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [gqv_pkg::CFG_W-1:0] cfg_data
);
  import gqv_pkg::*;

  gqv_cmd_t cmd;
  gqv_sts_t sts;

  gqv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gqv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_ch.kind),
    .in_char_code    (in_ch.char_code),
    .in_start_x      (in_ch.start_x),
    .in_start_y      (in_ch.start_y),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_pos_x       (out_ch.pos_x),
    .out_pos_y       (out_ch.pos_y),
    .out_tex_u       (out_ch.tex_u),
    .out_tex_v       (out_ch.tex_v),
    .out_last_vertex (out_ch.last_vertex)
  );

endmodule
`default_nettype wire

@@ tb/sv/glyph_quad_vertex_generator_test.sv @@
// stimulus and checks for the glyph quad vertex generator: a request table, then random phases
`timescale 1ns / 1ps
module glyph_quad_vertex_generator_test;
  import gqv_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam int WATCHDOG_MAX = 2000;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 20;
  localparam int SHOW_MAX     = 10;
  localparam int DIR_N        = 16;

  localparam longint POS_HI  = 64'sd8388607;
  localparam longint POS_LO  = -64'sd8388608;
  localparam longint TEX_ONE = 64'sd65536;

  localparam logic             KIND_GLYPH = ~KIND_START;
  localparam logic [IDX_W-1:0] REG_SPARE  = 3'd7;

  typedef struct packed {
    logic [23:0] x0;
    logic [23:0] x1;
    logic [23:0] y0;
    logic [23:0] y1;
    logic [16:0] u0;
    logic [16:0] u1;
    logic [16:0] v0;
    logic [16:0] v1;
  } quad_t;

  typedef struct packed {
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        last_vertex;
  } vertex_t;

  typedef struct packed {
    logic        typed;
    quad_t       quad;
    logic        kind;
    logic [7:0]  code;
    logic [15:0] sx;
    logic [15:0] sy;
  } row_t;

  localparam quad_t NO_QUAD = '0;

  // typed quads hold for the reset register values
  localparam row_t DIR_TAB [DIR_N] = '{
    '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd4096, 17'd2048, 17'd2048, 17'd0, 17'd4096},
      KIND_GLYPH, 8'h00, 16'h0000, 16'h0000},
    '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd4096, 17'd63488, 17'd63488, 17'd61440, 17'd65536},
      KIND_GLYPH, 8'hFF, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_GLYPH, CHAR_NEWLINE, 16'h1234, 16'hEDCB},
    '{1'b1, '{24'd0, 24'd0, 24'd4096, 24'd8192, 17'd6144, 17'd6144, 17'd16384, 17'd20480},
      KIND_GLYPH, 8'h41, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_START, 8'hFF, 16'h7FFF, 16'h8000},
    '{1'b0, NO_QUAD, KIND_GLYPH, 8'h0F, 16'hFFFF, 16'hFFFF},
    '{1'b0, NO_QUAD, KIND_GLYPH, CHAR_NEWLINE, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_START, CHAR_NEWLINE, 16'h8000, 16'h7FFF},
    '{1'b0, NO_QUAD, KIND_GLYPH, 8'hF0, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_GLYPH, CHAR_NEWLINE, 16'h0000, 16'h0000},
    '{1'b1, '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
              17'd2048, 17'd2048, 17'd32768, 17'd36864},
      KIND_GLYPH, 8'h80, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_GLYPH, 8'h0B, 16'h5555, 16'hAAAA},
    '{1'b0, NO_QUAD, KIND_GLYPH, 8'h09, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_GLYPH, 8'h7F, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_START, 8'h00, 16'h0000, 16'h0000},
    '{1'b0, NO_QUAD, KIND_GLYPH, 8'h01, 16'h0000, 16'h0000}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gqv_in_if  in_ch();
  gqv_out_if out_ch();

  glyph_quad_vertex_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the registers and the pen
  logic [8:0]  cell_w;
  logic [8:0]  cell_h;
  logic [15:0] scale;
  logic [24:0] inv_w;
  logic [24:0] inv_h;
  logic [7:0]  marg_l;
  logic [7:0]  marg_r;
  longint      pen_x;
  longint      pen_y;
  longint      line_x;

  vertex_t pending_vertices[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      idle_on = 1'b1;
  bit      hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // q1.24 times texels, floored to q1.16, clamped to 0..1.0
  function automatic logic [16:0] tex_q16(input longint inv, input longint texels);
    longint p;
    p = inv * texels;
    if (p <= 0) return '0;
    p = p / 256;
    if (p > TEX_ONE) return 17'd65536;
    return 17'(p);
  endfunction

  task automatic compute_glyph_quad(input logic kind, input logic [7:0] code,
                                    input logic signed [15:0] sx,
                                    input logic signed [15:0] sy,
                                    output bit emits, output quad_t q);
    longint mx, my, cw, ch, sc, ml, mr, s_x, s_y, right;
    cw = cell_w;
    ch = cell_h;
    sc = scale;
    ml = marg_l;
    mr = marg_r;
    s_x = sx;
    s_y = sy;
    emits = 1'b0;
    q = '0;
    if (kind == KIND_START) begin
      line_x = s_x * 256;
      pen_x = line_x;
      pen_y = s_y * 256;
    end else if (code == CHAR_NEWLINE) begin
      pen_x = line_x;
      pen_y = clamp_pos(pen_y + sc * ch);
    end else begin
      mx = code[3:0];
      my = code[7:4];
      // margins can exceed the cell, then the right edge sits left of the pen
      right = clamp_pos(pen_x + sc * cw - sc * (ml + mr));
      q.x0 = 24'(pen_x);
      q.x1 = 24'(right);
      q.y0 = 24'(pen_y);
      q.y1 = 24'(clamp_pos(pen_y + sc * ch));
      q.u0 = tex_q16(longint'(inv_w), mx * cw + ml);
      q.u1 = tex_q16(longint'(inv_w), (mx + 1) * cw - mr);
      q.v0 = tex_q16(longint'(inv_h), my * ch);
      q.v1 = tex_q16(longint'(inv_h), (my + 1) * ch);
      pen_x = right;
      emits = 1'b1;
    end
  endtask

  task automatic send_request(input logic kind, input logic [7:0] code,
                              input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input bit typed, input quad_t typed_quad);
    int      gap;
    bit      emits;
    quad_t   q;
    vertex_t v;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.char_code <= code;
    in_ch.start_x   <= sx;
    in_ch.start_y   <= sy;
    do @(posedge clk); while (!in_ch.ready);
    compute_glyph_quad(kind, code, sx, sy, emits, q);
    if (typed) q = typed_quad;
    if (emits) begin
      // corners in the order (0,0) (1,0) (1,1) (0,1)
      for (int k = 0; k < 4; k++) begin
        v.pos_x       = (k == 1 || k == 2) ? q.x1 : q.x0;
        v.tex_u       = (k == 1 || k == 2) ? q.u1 : q.u0;
        v.pos_y       = (k >= 2) ? q.y1 : q.y0;
        v.tex_v       = (k >= 2) ? q.v1 : q.v0;
        v.last_vertex = (k == 3);
        pending_vertices = {pending_vertices, v};
      end
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CELL_W:   cell_w = data[8:0];
      REG_CELL_H:   cell_h = data[8:0];
      REG_SCALE:    scale  = data[15:0];
      REG_INV_W:    inv_w  = data[24:0];
      REG_INV_H:    inv_h  = data[24:0];
      REG_MARGIN_L: marg_l = data[7:0];
      REG_MARGIN_R: marg_r = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drains the block, then writes every register
  task automatic load_config(input logic [CFG_W-1:0] cw, input logic [CFG_W-1:0] ch,
                             input logic [CFG_W-1:0] sc, input logic [CFG_W-1:0] iw,
                             input logic [CFG_W-1:0] ih, input logic [CFG_W-1:0] ml,
                             input logic [CFG_W-1:0] mr, input bit poke_spare);
    in_ch.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    // a trailing newline or start request may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_CELL_W, cw);
    write_reg(REG_CELL_H, ch);
    write_reg(REG_SCALE, sc);
    write_reg(REG_INV_W, iw);
    write_reg(REG_INV_H, ih);
    write_reg(REG_MARGIN_L, ml);
    write_reg(REG_MARGIN_R, mr);
    if (poke_spare) write_reg(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls while idle_on is set, one long hold-off on request
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    vertex_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.pos_x, out_ch.pos_y, out_ch.tex_u, out_ch.tex_v, out_ch.last_vertex};
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected vertex: x=%0d y=%0d u=%0d v=%0d last=%0b",
                   $signed(got.pos_x), $signed(got.pos_y), got.tex_u, got.tex_v,
                   got.last_vertex);
      end else begin
        want = pending_vertices.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.tex_u !== want.tex_u || got.tex_v !== want.tex_v ||
            got.last_vertex !== want.last_vertex) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("vertex mismatch: expected x=%0d y=%0d u=%0d v=%0d last=%0b,",
                     $signed(want.pos_x), $signed(want.pos_y), want.tex_u, want.tex_v,
                     want.last_vertex,
                     " got x=%0d y=%0d u=%0d v=%0d last=%0b",
                     $signed(got.pos_x), $signed(got.pos_y), got.tex_u, got.tex_v,
                     got.last_vertex);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                 kind_pick;
    int                 cw_pick;
    int                 ch_pick;
    logic               kind;
    logic [7:0]         code;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_START;
    in_ch.char_code <= '0;
    in_ch.start_x   <= '0;
    in_ch.start_y   <= '0;
    cell_w = RST_CELL_W;
    cell_h = RST_CELL_H;
    scale  = RST_SCALE;
    inv_w  = RST_INV_W;
    inv_h  = RST_INV_H;
    marg_l = RST_MARGIN_L;
    marg_r = RST_MARGIN_R;
    pen_x  = 0;
    pen_y  = 0;
    line_x = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_request(DIR_TAB[i].kind, DIR_TAB[i].code, DIR_TAB[i].sx, DIR_TAB[i].sy,
                   DIR_TAB[i].typed, DIR_TAB[i].quad);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        // margins wider than the cell
        1: load_config(25'd256, 25'd256, 25'd65535, 25'd16777216, 25'd16777216,
                       25'd255, 25'd255, 1'b0);
        // all ones: every field at its widest value
        3: load_config('1, '1, '1, '1, '1, '1, '1, 1'b0);
        4: load_config(25'd1, 25'd1, 25'd1, 25'd1, 25'd1, 25'd0, 25'd0, 1'b0);
        // degenerate quads from zero scale and zero cell size
        5: load_config('0, '0, '0, '0, '0, '0, '0, 1'b0);
        6: load_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                       CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                       CFG_W'($urandom), 1'b1);
        default: begin
          cw_pick = $urandom_range(1, 32);
          ch_pick = $urandom_range(1, 32);
          load_config(CFG_W'(cw_pick), CFG_W'(ch_pick), CFG_W'($urandom_range(32, 2048)),
                      CFG_W'(16777216 / (16 * cw_pick)), CFG_W'(16777216 / (16 * ch_pick)),
                      CFG_W'($urandom_range(0, cw_pick)), CFG_W'($urandom_range(0, cw_pick)),
                      1'b0);
        end
      endcase
      if (p == 2) hold_req = 1'b1;
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind_pick = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        sx = 16'($urandom);
        sy = 16'($urandom);
        if (kind_pick < 8) begin
          kind = KIND_START;
        end else begin
          kind = KIND_GLYPH;
          if (kind_pick < 20) code = CHAR_NEWLINE;
        end
        send_request(kind, code, sx, sy, 1'b0, NO_QUAD);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gqv_pkg.sv
rtl/gqv_channels.sv
rtl/gqv_ctrl.sv
rtl/gqv_dp.sv
rtl/glyph_quad_vertex_generator.sv
tb/sv/glyph_quad_vertex_generator_test.sv
